### rtl/core/mts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mts_pkg
// Shared widths, action and fault codes, and the RAM request bundle for the
// minimum-tracking stack.
// ----------------------------------------------------------------------------
package mts_pkg;

    localparam int DEPTH  = 64;
    localparam int DATA_W = 32;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    localparam logic [1:0] ACT_PUSH = 2'd0;
    localparam logic [1:0] ACT_POP  = 2'd1;
    localparam logic [1:0] ACT_READ = 2'd2;

    localparam logic [1:0] FAULT_NONE  = 2'd0;
    localparam logic [1:0] FAULT_EMPTY = 2'd1;
    localparam logic [1:0] FAULT_FULL  = 2'd2;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [DATA_W-1:0] wr_data;
        logic [ADDR_W-1:0] rd_addr;
    } mem_req_t;

endpackage

### rtl/core/mts_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mts_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module mts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### rtl/core/mts_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mts_core
// Sequencer for the stack: keeps counts and cached tops, issues RAM writes
// on push and top refetch reads on pop, and holds the result register.
// ----------------------------------------------------------------------------
module mts_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   action,
    input  logic signed [31:0]           value,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [31:0]           top_value,
    output logic signed [31:0]           min_value,
    output logic                         is_empty,
    output logic [1:0]                   fault,
    output mts_pkg::mem_req_t            value_req,
    output mts_pkg::mem_req_t            min_req,
    input  logic [mts_pkg::DATA_W-1:0]   value_rd,
    input  logic [mts_pkg::DATA_W-1:0]   min_rd
);
    import mts_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_WAIT = 1'b1;

    logic              state_reg, state_next;
    logic [CNT_W-1:0]  vcnt_reg, vcnt_next;
    logic [CNT_W-1:0]  mcnt_reg, mcnt_next;
    logic signed [DATA_W-1:0] vtop_reg, vtop_next;
    logic signed [DATA_W-1:0] mtop_reg, mtop_next;
    logic              drop_reg, drop_next;

    logic              oval_reg, oval_next;
    logic signed [DATA_W-1:0] otop_reg, otop_next;
    logic signed [DATA_W-1:0] omin_reg, omin_next;
    logic              oempty_reg, oempty_next;
    logic [1:0]        ofault_reg, ofault_next;

    logic              accept;
    logic              load;
    logic              min_push;
    logic              drop_min;

    assign in_stall = (state_reg != S_IDLE) || (oval_reg && out_stall);
    assign accept   = in_valid && !in_stall;

    assign min_push = (mcnt_reg < CNT_W'(DEPTH))
                   && ((mcnt_reg == '0) || (value <= mtop_reg));
    assign drop_min = (mcnt_reg != '0) && (vtop_reg == mtop_reg);

    always_comb
    begin
        state_next  = state_reg;
        vcnt_next   = vcnt_reg;
        mcnt_next   = mcnt_reg;
        vtop_next   = vtop_reg;
        mtop_next   = mtop_reg;
        drop_next   = drop_reg;
        load        = 1'b0;
        ofault_next = FAULT_NONE;

        value_req.wr_en   = 1'b0;
        value_req.wr_addr = vcnt_reg[ADDR_W-1:0];
        value_req.wr_data = value;
        value_req.rd_addr = ADDR_W'(vcnt_reg - CNT_W'(2));
        min_req.wr_en     = 1'b0;
        min_req.wr_addr   = mcnt_reg[ADDR_W-1:0];
        min_req.wr_data   = value;
        min_req.rd_addr   = ADDR_W'(mcnt_reg - CNT_W'(2));

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (action)
                        ACT_PUSH:
                        begin
                            load = 1'b1;
                            if (vcnt_reg == CNT_W'(DEPTH))
                            begin
                                ofault_next = FAULT_FULL;
                            end
                            else
                            begin
                                value_req.wr_en = 1'b1;
                                vcnt_next       = vcnt_reg + CNT_W'(1);
                                vtop_next       = value;
                                if (min_push)
                                begin
                                    min_req.wr_en = 1'b1;
                                    mcnt_next     = mcnt_reg + CNT_W'(1);
                                    mtop_next     = value;
                                end
                            end
                        end
                        ACT_POP:
                        begin
                            if (vcnt_reg == '0)
                            begin
                                load        = 1'b1;
                                ofault_next = FAULT_EMPTY;
                            end
                            else
                            begin
                                // refetch the new tops next cycle
                                vcnt_next  = vcnt_reg - CNT_W'(1);
                                mcnt_next  = drop_min ? mcnt_reg - CNT_W'(1) : mcnt_reg;
                                drop_next  = drop_min;
                                state_next = S_WAIT;
                            end
                        end
                        default:
                        begin
                            load = 1'b1;
                        end
                    endcase
                end
            end
            S_WAIT:
            begin
                load       = 1'b1;
                vtop_next  = value_rd;
                if (drop_reg)
                begin
                    mtop_next = min_rd;
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        oval_next   = oval_reg && out_stall;
        if (load)
        begin
            oval_next = 1'b1;
        end
        otop_next   = (vcnt_next != '0) ? vtop_next : '0;
        omin_next   = ((vcnt_next != '0) && (mcnt_next != '0)) ? mtop_next : '0;
        oempty_next = (vcnt_next == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            vcnt_reg  <= '0;
            mcnt_reg  <= '0;
            drop_reg  <= 1'b0;
            oval_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            vcnt_reg  <= vcnt_next;
            mcnt_reg  <= mcnt_next;
            drop_reg  <= drop_next;
            oval_reg  <= oval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vtop_reg <= vtop_next;
        mtop_reg <= mtop_next;
        if (load)
        begin
            otop_reg   <= otop_next;
            omin_reg   <= omin_next;
            oempty_reg <= oempty_next;
            ofault_reg <= ofault_next;
        end
    end

    assign out_valid = oval_reg;
    assign top_value = otop_reg;
    assign min_value = omin_reg;
    assign is_empty  = oempty_reg;
    assign fault     = ofault_reg;

    a_min_not_deeper: assert property (@(posedge clk) disable iff (!rst_n)
        mcnt_reg <= vcnt_reg)
        else $error("minimum stack deeper than value stack");

    a_min_present: assert property (@(posedge clk) disable iff (!rst_n)
        (vcnt_reg != '0) |-> (mcnt_reg != '0))
        else $error("non-empty stack without a minimum");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vcnt_reg <= CNT_W'(DEPTH))
        else $error("value count past depth");

    a_wait_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WAIT) |=> (state_reg == S_IDLE) && oval_reg)
        else $error("pop refetch did not produce a result");

endmodule

### rtl/core/min_tracking_stack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_tracking_stack
// Bounded stack of signed values that reports its running minimum.
// ----------------------------------------------------------------------------
// Timing: push, read and faulted items load the result register on acceptance;
//   a pop passes first through the wait state, which refetches the new tops
//   via the registered RAM read ports. Throughput: one push or read per cycle
//   while out_stall holds no result; a pop stalls the input during its refetch.
// Reset: clears both counts and all handshake state; the RAMs are not cleared
//   and need no clearing pass, since no unwritten entry reaches a result.
// ----------------------------------------------------------------------------
module min_tracking_stack (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         action,
    input  logic signed [31:0] value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] top_value,
    output logic signed [31:0] min_value,
    output logic               is_empty,
    output logic [1:0]         fault
);
    import mts_pkg::*;

    // RAM request bundles from the sequencer and the registered read data
    mem_req_t          value_req;
    mem_req_t          min_req;
    logic [DATA_W-1:0] value_rd;
    logic [DATA_W-1:0] min_rd;

    // Sequencer: counts, cached tops, pop refetch and the result register.
    // Pushes write the item at the current count; pops read the new top, the
    // entry just below the old one, so a read never meets a write to the same
    // entry.
    mts_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .top_value (top_value),
        .min_value (min_value),
        .is_empty  (is_empty),
        .fault     (fault),
        .value_req (value_req),
        .min_req   (min_req),
        .value_rd  (value_rd),
        .min_rd    (min_rd)
    );

    // Main stack storage
    mts_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_value_ram (
        .clk     (clk),
        .wr_en   (value_req.wr_en),
        .wr_addr (value_req.wr_addr),
        .wr_data (value_req.wr_data),
        .rd_addr (value_req.rd_addr),
        .rd_data (value_rd)
    );

    // Running-minimum stack storage
    mts_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_min_ram (
        .clk     (clk),
        .wr_en   (min_req.wr_en),
        .wr_addr (min_req.wr_addr),
        .wr_data (min_req.wr_data),
        .rd_addr (min_req.rd_addr),
        .rd_data (min_rd)
    );

endmodule

### sim/min_tracking_stack_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_tracking_stack_checker
// Watches both channels of the minimum-tracking stack, keeps its own copy of
// the two stacks, predicts the result of every accepted item and compares
// each accepted result against the oldest prediction.
// ----------------------------------------------------------------------------
module min_tracking_stack_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [1:0]         action,
    input  logic signed [31:0] value,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [31:0] top_value,
    input  logic signed [31:0] min_value,
    input  logic               is_empty,
    input  logic [1:0]         fault,
    output int                 fail_count,
    output int                 pending
);

    import mts_pkg::*;

    typedef struct packed {
        logic signed [31:0] top;
        logic signed [31:0] min;
        logic               empty;
        logic [1:0]         fault;
    } stack_view_t;

    stack_view_t  view_q[$];

    logic [31:0]  shadow_vals [DEPTH];
    logic [31:0]  shadow_mins [DEPTH];
    int unsigned  val_count;
    int unsigned  min_count;

    initial
    begin
        fail_count = 0;
        pending    = 0;
        val_count  = 0;
        min_count  = 0;
    end

    // Apply one item to the shadow stacks and return the view after it.
    function automatic stack_view_t apply_stack_op(logic [1:0] act, logic [31:0] val);
        stack_view_t v;
        v.fault = FAULT_NONE;
        if (act == ACT_PUSH)
        begin
            if (val_count >= DEPTH)
                v.fault = FAULT_FULL;
            else
            begin
                shadow_vals[val_count] = val;
                val_count++;
                if (min_count < DEPTH &&
                    (min_count == 0 || $signed(val) <= $signed(shadow_mins[min_count - 1])))
                begin
                    shadow_mins[min_count] = val;
                    min_count++;
                end
            end
        end
        else if (act == ACT_POP)
        begin
            if (val_count == 0)
                v.fault = FAULT_EMPTY;
            else
            begin
                if (min_count > 0 && shadow_vals[val_count - 1] == shadow_mins[min_count - 1])
                    min_count--;
                val_count--;
            end
        end
        v.top   = (val_count > 0) ? shadow_vals[val_count - 1] : 32'd0;
        v.min   = (val_count > 0 && min_count > 0) ? shadow_mins[min_count - 1] : 32'd0;
        v.empty = (val_count == 0);
        return v;
    endfunction

    task automatic log_mismatch(bit orphan, stack_view_t want, stack_view_t got);
        fail_count++;
        if (fail_count <= 10)
        begin
            if (orphan)
                $display("unexpected result: top=%0d min=%0d empty=%0d fault=%0d",
                         $signed(got.top), $signed(got.min), got.empty, got.fault);
            else
                $display("mismatch: expected top=%0d min=%0d empty=%0d fault=%0d, got top=%0d min=%0d empty=%0d fault=%0d",
                         $signed(want.top), $signed(want.min), want.empty, want.fault,
                         $signed(got.top), $signed(got.min), got.empty, got.fault);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        stack_view_t got;
        stack_view_t want;
        if (!rst_n)
        begin
            val_count = 0;
            min_count = 0;
            view_q.delete();
            pending <= 0;
        end
        else
        begin
            if (out_valid === 1'b1 && out_stall === 1'b0)
            begin
                got = '{top: top_value, min: min_value, empty: is_empty, fault: fault};
                if (view_q.size() == 0)
                    log_mismatch(1'b1, got, got);
                else
                begin
                    want = view_q.pop_front();
                    if (got !== want)
                        log_mismatch(1'b0, want, got);
                end
            end
            if (in_valid === 1'b1 && in_stall === 1'b0)
                view_q.push_back(apply_stack_op(action, value));
            pending <= view_q.size();
        end
    end

endmodule

### sim/min_tracking_stack_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_tracking_stack_tb
// Drives the minimum-tracking stack with a short directed run and then with
// fill, drain and even bursts of random actions under three idling mixes;
// a checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module min_tracking_stack_tb;

    import mts_pkg::*;

    // Spare action code; the block treats it as a read.
    localparam logic [1:0]         ACT_SPARE = 2'd3;
    localparam logic signed [31:0] INT_MIN   = 32'sh8000_0000;
    localparam logic signed [31:0] INT_MAX   = 32'sh7fff_ffff;
    localparam int                 LONG_HOLD = 300;
    localparam int                 PHASE_ITEMS = 460;
    localparam int                 TAIL_CYCLES = 8;
    localparam int                 TIMEOUT_NS = 2_000_000;

    typedef enum int { MIX_FILL, MIX_DRAIN, MIX_EVEN } op_mix_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         action;
    logic signed [31:0] value;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] top_value;
    logic signed [31:0] min_value;
    logic               is_empty;
    logic [1:0]         fault;

    int                 fail_count;
    int                 pending;
    int                 rx_idle_pct;
    int                 tx_idle_pct;
    logic               hold_req;

    min_tracking_stack u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .top_value (top_value),
        .min_value (min_value),
        .is_empty  (is_empty),
        .fault     (fault)
    );

    min_tracking_stack_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .value      (value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .top_value  (top_value),
        .min_value  (min_value),
        .is_empty   (is_empty),
        .fault      (fault),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // 4 ns clock.
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #(TIMEOUT_NS);
        $display("Verification failed");
        $finish;
    end

    // Result side: stall at the current idle rate; on request, hold off for a
    // long stretch so the block backs up and stalls its input.
    initial
    begin : receiver
        int   hold_left;
        logic hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
        end
    end

    // Offer one item after a random idle gap and hold it until accepted.
    task automatic send_item(logic [1:0] act, logic signed [31:0] val);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        value    <= val;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Drop valid and wait until every predicted result has come back.
    task automatic pause_until_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // Many small values so equal minima are common, plus extremes and
    // full-width noise so every bit toggles.
    function automatic logic signed [31:0] pick_value();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return $signed($urandom_range(0, 16)) - 8;
        else if (r < 55)
        begin
            case ($urandom_range(0, 3))
                0:       return INT_MIN;
                1:       return INT_MAX;
                2:       return 32'sd0;
                default: return -32'sd1;
            endcase
        end
        return $urandom;
    endfunction

    function automatic logic [1:0] pick_action(op_mix_t mix);
        int unsigned r;
        int          push_pct;
        r = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:  push_pct = 78;
            MIX_DRAIN: push_pct = 18;
            default:   push_pct = 45;
        endcase
        if (r < push_pct)
            return ACT_PUSH;
        else if (r < 90)
            return ACT_POP;
        else if (r < 96)
            return ACT_READ;
        return ACT_SPARE;
    endfunction

    // Push-only run past the depth: hits the full stack and push on full.
    task automatic fill_to_full(inout int sent);
        for (int i = 0; i < DEPTH + 6; i++)
        begin
            send_item(ACT_PUSH, pick_value());
            sent++;
        end
    endtask

    initial
    begin : stimulus
        int rx_pct [3];
        int tx_pct [3];
        int sent;
        int burst_len;
        op_mix_t mix;

        rx_pct = '{75, 33, 0};
        tx_pct = '{33, 75, 0};

        rst_n       = 1'b0;
        in_valid    = 1'b0;
        action      = ACT_READ;
        value       = '0;
        hold_req    = 1'b0;
        rx_idle_pct = 0;
        tx_idle_pct = 0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty-stack cases, extremes, duplicate minima, spare code.
        send_item(ACT_READ,  32'sd0);
        send_item(ACT_POP,   32'sd5);      // pop on empty
        send_item(ACT_SPARE, INT_MAX);     // spare code on empty
        send_item(ACT_PUSH,  32'sd0);
        send_item(ACT_PUSH,  INT_MAX);
        send_item(ACT_PUSH,  INT_MIN);
        send_item(ACT_PUSH,  INT_MIN);     // equal to minimum, stacked again
        send_item(ACT_READ,  32'sd7);
        send_item(ACT_POP,   32'sd0);      // duplicate minimum survives
        send_item(ACT_POP,   32'sd0);
        send_item(ACT_PUSH,  -32'sd1);
        send_item(ACT_PUSH,  -32'sd1);
        send_item(ACT_PUSH,  32'sd5);
        send_item(ACT_SPARE, 32'sd0);
        send_item(ACT_POP,   32'sd0);
        send_item(ACT_POP,   32'sd0);
        send_item(ACT_POP,   32'sd0);
        send_item(ACT_PUSH,  32'sh5555_5555);
        send_item(ACT_PUSH,  32'shaaaa_aaaa);
        send_item(ACT_POP,   32'sd0);
        send_item(ACT_POP,   32'sd0);
        send_item(ACT_POP,   32'sd0);
        send_item(ACT_POP,   32'sd0);      // back to empty

        // Random: three idling mixes, each opening with a fill to full and
        // then bursts of fill, drain and even mixes with random content.
        for (int p = 0; p < 3; p++)
        begin
            pause_until_drained();
            rx_idle_pct <= rx_pct[p];
            tx_idle_pct  = tx_pct[p];
            if (p == 2)
                hold_req <= 1'b1;          // long receiver hold during the fill
            sent = 0;
            fill_to_full(sent);
            while (sent < PHASE_ITEMS)
            begin
                mix       = op_mix_t'($urandom_range(0, 2));
                burst_len = $urandom_range(20, 150);
                for (int i = 0; i < burst_len && sent < PHASE_ITEMS; i++)
                begin
                    send_item(pick_action(mix), pick_value());
                    sent++;
                end
            end
        end

        pause_until_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
